### hdl/prrjq_pkg.sv
// Package for the priority round-robin job queue.
// Holds the transaction payload types, status codes and controller states.
// No dependencies.
`default_nettype none
package prrjq_pkg;

   localparam logic [7:0] SLICE_RESET = 8'd25;

   localparam logic OP_SUBMIT   = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [15:0] job_id;
      logic [7:0]  job_length;
      logic [3:0]  job_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] run_job_id;
      logic [7:0]  time_used;
      logic [7:0]  time_left;
      logic        first_run;
      logic        finished;
      logic [4:0]  jobs_held;
   } rsp_type;

   // Outcome of one turn of a dispatched job.
   typedef struct packed {
      logic [7:0] used;
      logic [7:0] left;
      logic       first;
      logic       fin;
   } run_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_READ
   } fsm_type;

endpackage
`default_nettype wire

### hdl/prrjq_slice_calc.sv
// Time slice arithmetic for one dispatched job.
// Depends on prrjq_pkg for run_type.
`default_nettype none
module prrjq_slice_calc (
   input  wire logic [7:0]        remaining,
   input  wire logic [7:0]        burst,
   input  wire logic [7:0]        slice_cfg,
   input  wire logic              sole,
   output prrjq_pkg::run_type     run
);
   import prrjq_pkg::*;

   logic [7:0] slice;

   always_comb begin
      // A zero slice behaves as a slice of one unit.
      slice = (slice_cfg == 8'd0) ? 8'd1 : slice_cfg;
      run.first = (remaining == burst);
      if (remaining <= slice || sole) begin
         run.used = remaining;
         run.left = 8'd0;
      end else begin
         run.used = slice;
         run.left = remaining - slice;
      end
      run.fin = (run.left == 8'd0);
   end

endmodule
`default_nettype wire

### hdl/priority_round_robin_job_queue_top.sv
// Top level of the priority round-robin job queue.
// Depends on prrjq_pkg and prrjq_slice_calc.
`default_nettype none
// Jobs are held in a slot memory and chained into one linked FIFO per priority
// level; the head of the lowest occupied level is served next, and a job that
// only used a slice is appended to the tail of its level. A dispatch passes
// through a read state, as the slot and link memories are read through
// registers. A submit to a full table returns status 1, a dispatch of an empty
// table returns status 2. No clearing pass follows reset.
module priority_round_robin_job_queue_top #(
   parameter int DEPTH  = 16,
   parameter int LEVELS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire prrjq_pkg::req_type req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      prrjq_pkg::rsp_type rsp_data,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [7:0]         csr_wdata
);
   import prrjq_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  burst;
      logic [7:0]  remaining;
   } entry_type;

   entry_type       job_mem [DEPTH];
   logic [PW-1:0]   next_mem [DEPTH];
   entry_type       job_rd_ff;
   logic [PW-1:0]   next_rd_ff;

   fsm_type         state_ff, state_in;
   logic [DEPTH-1:0] free_ff;
   logic [CW-1:0]   cnt_ff [LEVELS];
   logic [PW-1:0]   head_ff [LEVELS];
   logic [PW-1:0]   tail_ff [LEVELS];
   logic [CW-1:0]   fill_ff;
   logic [7:0]      slice_ff;
   logic [LW-1:0]   lvl_ff;
   logic [PW-1:0]   slot_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            accept, is_submit, full, do_submit, do_read;
   logic [LW-1:0]   sub_lvl, pick_lvl;
   logic [PW-1:0]   free_slot;
   logic            jm_we, nx_we;
   logic [PW-1:0]   jm_waddr, nx_waddr, nx_wdata;
   entry_type       jm_wdata;
   run_type         run;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Lowest occupied level and lowest free slot.
   always_comb begin
      pick_lvl  = '0;
      free_slot = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (cnt_ff[l] != '0) pick_lvl = LW'(l);
      end
      for (int s = DEPTH - 1; s >= 0; s--) begin
         if (free_ff[s]) free_slot = PW'(s);
      end
   end

   always_comb begin
      if (32'(req_data.job_priority) >= LEVELS) sub_lvl = LW'(LEVELS - 1);
      else sub_lvl = LW'(req_data.job_priority);
   end

   assign req_ready = (state_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_submit = (req_data.opcode == OP_SUBMIT);
   assign full      = (fill_ff == CW'(DEPTH));
   assign do_submit = accept && is_submit && !full;
   assign do_read   = (state_ff == FSM_READ);

   prrjq_slice_calc u_slice (
      .remaining (job_rd_ff.remaining),
      .burst     (job_rd_ff.burst),
      .slice_cfg (slice_ff),
      .sole      (cnt_ff[lvl_ff] == CW'(1)),
      .run       (run)
   );

   // Memory write ports: a submit writes a new slot, a slice-only turn writes back
   // the remaining time; each links the slot behind the tail of a non-empty level.
   always_comb begin
      jm_we    = 1'b0;
      jm_waddr = free_slot;
      jm_wdata = '{id: req_data.job_id, burst: req_data.job_length,
                   remaining: req_data.job_length};
      nx_we    = 1'b0;
      nx_waddr = tail_ff[sub_lvl];
      nx_wdata = free_slot;
      if (do_submit) begin
         jm_we = 1'b1;
         nx_we = (cnt_ff[sub_lvl] != '0);
      end else if (do_read && !run.fin) begin
         jm_we    = 1'b1;
         jm_waddr = slot_ff;
         jm_wdata = '{id: job_rd_ff.id, burst: job_rd_ff.burst,
                      remaining: run.left};
         nx_we    = 1'b1;
         nx_waddr = tail_ff[lvl_ff];
         nx_wdata = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (jm_we) job_mem[jm_waddr] <= jm_wdata;
      if (nx_we) next_mem[nx_waddr] <= nx_wdata;
      job_rd_ff  <= job_mem[head_ff[pick_lvl]];
      next_rd_ff <= next_mem[head_ff[pick_lvl]];
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               if (is_submit) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.status    = full ? STATUS_FULL : STATUS_DONE;
                  rsp_in.jobs_held = full ? 5'(fill_ff) : 5'(fill_ff + CW'(1));
               end else if (fill_ff == '0) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.status    = STATUS_EMPTY;
                  rsp_in.jobs_held = 5'(fill_ff);
               end else begin
                  state_in = FSM_READ;
               end
            end
         end
         FSM_READ: begin
            state_in          = FSM_IDLE;
            rsp_valid_in      = 1'b1;
            rsp_in.status     = STATUS_DONE;
            rsp_in.run_job_id = job_rd_ff.id;
            rsp_in.time_used  = run.used;
            rsp_in.time_left  = run.left;
            rsp_in.first_run  = run.first;
            rsp_in.finished   = run.fin;
            rsp_in.jobs_held  = run.fin ? 5'(fill_ff - CW'(1)) : 5'(fill_ff);
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         lvl_ff  <= pick_lvl;
         slot_ff <= head_ff[pick_lvl];
      end
      if (do_submit) begin
         if (cnt_ff[sub_lvl] == '0) head_ff[sub_lvl] <= free_slot;
         tail_ff[sub_lvl] <= free_slot;
      end else if (do_read) begin
         head_ff[lvl_ff] <= next_rd_ff;
         if (!run.fin) tail_ff[lvl_ff] <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         free_ff      <= '1;
         fill_ff      <= '0;
         slice_ff     <= SLICE_RESET;
         for (int l = 0; l < LEVELS; l++) cnt_ff[l] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) slice_ff <= csr_wdata;
         if (do_submit) begin
            free_ff[free_slot] <= 1'b0;
            cnt_ff[sub_lvl]    <= cnt_ff[sub_lvl] + CW'(1);
            fill_ff            <= fill_ff + CW'(1);
         end else if (do_read && run.fin) begin
            free_ff[slot_ff] <= 1'b1;
            cnt_ff[lvl_ff]   <= cnt_ff[lvl_ff] - CW'(1);
            fill_ff          <= fill_ff - CW'(1);
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count exceeds table depth");

   a_free_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(free_ff) + 32'(fill_ff) == DEPTH)
      else $error("free slot map disagrees with fill count");

   a_read_level: assert property (@(posedge clock) disable iff (reset)
      do_read |-> cnt_ff[lvl_ff] != '0)
      else $error("dispatch read of an empty level");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      accept && is_submit && full |=> rsp_valid_ff && rsp_ff.status == STATUS_FULL)
      else $error("dropped submit not reported");

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the priority round-robin job queue.
// Depends on prrjq_pkg and priority_round_robin_job_queue_top; holds its own job scheduler model.
`default_nettype none
module testbench;
   import prrjq_pkg::*;

   localparam int NJOBS = 16;
   localparam int NLEV = 16;
   localparam int WATCHDOG = 20000;

   typedef struct {
      logic [15:0] id;
      logic [7:0]  burst;
      logic [7:0]  remain;
      logic [3:0]  prio;
   } job_slot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_wdata = '0;

   priority_round_robin_job_queue_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Scheduler state mirrored by the testbench.
   job_slot_type sched_jobs[NJOBS];
   int sched_fill;
   int sched_level_cnt[NLEV];
   logic [7:0] sched_slice;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int mismatches = 0;
   int rsp_count = 0;
   int n_dispatch = 0, n_full = 0, n_empty = 0, n_finish = 0;
   int idle_cycles = 0;
   int burst_left = 0, gap_left = 0;
   int stall_phase = 0;
   logic [7:0] cfg_queue[$];

   function automatic void insert_job(job_slot_type e);
      int pos;
      pos = 0;
      while (pos < sched_fill && sched_jobs[pos].prio <= e.prio) pos++;
      if (sched_fill >= NJOBS) return;
      for (int i = sched_fill; i > pos; i--) sched_jobs[i] = sched_jobs[i-1];
      sched_jobs[pos] = e;
      sched_fill++;
   endfunction

   function automatic rsp_type schedule_step(req_type r);
      rsp_type o;
      job_slot_type h;
      logic [7:0] sl;
      o = '0;
      if (r.opcode == OP_SUBMIT) begin
         h.id = r.job_id; h.burst = r.job_length; h.remain = r.job_length;
         h.prio = r.job_priority;
         if (sched_fill >= NJOBS) begin
            o.status = STATUS_FULL;
         end else begin
            sched_level_cnt[h.prio]++;
            insert_job(h);
         end
      end else if (sched_fill == 0) begin
         o.status = STATUS_EMPTY;
      end else begin
         h = sched_jobs[0];
         sl = (sched_slice == 0) ? 8'd1 : sched_slice;
         for (int i = 0; i + 1 < sched_fill; i++) sched_jobs[i] = sched_jobs[i+1];
         sched_fill--;
         o.status = STATUS_DONE;
         o.run_job_id = h.id;
         o.first_run = (h.remain == h.burst);
         if (h.remain <= sl || sched_level_cnt[h.prio] == 1) begin
            o.time_used = h.remain;
            h.remain = 0;
         end else begin
            o.time_used = sl;
            h.remain = h.remain - sl;
         end
         o.time_left = h.remain;
         if (h.remain == 0) begin
            o.finished = 1'b1;
            if (sched_level_cnt[h.prio] > 0) sched_level_cnt[h.prio]--;
         end else begin
            insert_job(h);
         end
      end
      o.jobs_held = 5'(sched_fill);
      return o;
   endfunction

   // Driver: bursts of requests with random gaps; config writes go out alone.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            sched_slice = csr_wdata;
            csr_valid <= 1'b0;
         end else if (!csr_valid && cfg_queue.size() > 0) begin
            csr_wdata <= cfg_queue.pop_front();
            csr_valid <= 1'b1;
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(schedule_step(req_data));
            idle_cycles = 0;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares every response with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %p", rsp_data);
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e.status == STATUS_FULL) n_full++;
               if (e.status == STATUS_EMPTY) n_empty++;
               if (e.run_job_id != 0 || e.time_used != 0 || e.finished) n_dispatch++;
               if (e.finished) n_finish++;
               if (rsp_data !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response %0d mismatch: expected %p, got %p",
                              rsp_count, e, rsp_data);
               end
            end
         end
         // Stall pattern: long open stretches, then choppy periods.
         stall_phase = (stall_phase + 1) % 200;
         if (stall_phase < 60) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 2) != 0);
         if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic req_type mk_submit(logic [15:0] id, logic [7:0] b, logic [3:0] p);
      req_type r;
      r.opcode = OP_SUBMIT; r.job_id = id; r.job_length = b; r.job_priority = p;
      return r;
   endfunction

   function automatic req_type mk_dispatch();
      req_type r;
      r = '0;
      r.opcode = OP_DISPATCH;
      r.job_id = 16'($urandom);
      r.job_length = 8'($urandom);
      r.job_priority = 4'($urandom);
      return r;
   endfunction

   task automatic drain_then_write(logic [7:0] v);
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (8) @(posedge clock);
      cfg_queue.push_back(v);
      wait (cfg_queue.size() == 0);
      @(posedge clock);
      wait (!csr_valid);
      @(posedge clock);
   endtask

   // Random phase: mostly fill-and-serve rounds, some biased at the two lowest levels.
   task automatic random_phase(int n);
      int k;
      int narrow;
      k = 0;
      while (k < n) begin
         narrow = $urandom_range(0, 3);
         repeat ($urandom_range(1, 20)) begin
            logic [3:0] p;
            p = (narrow == 0) ? 4'($urandom_range(0, 1)) : 4'($urandom);
            pending_reqs.push_back(mk_submit(16'($urandom), 8'($urandom), p));
            k++;
         end
         repeat ($urandom_range(1, 24)) begin
            pending_reqs.push_back(mk_dispatch());
            k++;
         end
      end
   endtask

   initial begin
      sched_fill = 0;
      sched_slice = SLICE_RESET;
      foreach (sched_level_cnt[i]) sched_level_cnt[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty dispatch, extremes, zero burst, full table, lone job.
      pending_reqs.push_back(mk_dispatch());
      pending_reqs.push_back(mk_submit(16'hFFFF, 8'd255, 4'd15));
      pending_reqs.push_back(mk_submit(16'h0000, 8'd0, 4'd0));
      pending_reqs.push_back(mk_submit(16'h1234, 8'd100, 4'd0));
      pending_reqs.push_back(mk_submit(16'h5678, 8'd30, 4'd0));
      for (int i = 0; i < 13; i++)
         pending_reqs.push_back(mk_submit(16'(16'hA000 + i), 8'(i * 19 + 1), 4'(i)));
      repeat (7) pending_reqs.push_back(mk_dispatch());
      drain_then_write(8'd0);
      random_phase(250);
      drain_then_write(8'd255);
      random_phase(250);
      drain_then_write(8'd1);
      random_phase(350);
      drain_then_write(8'd7);
      random_phase(400);
      drain_then_write(8'($urandom_range(2, 254)));
      random_phase(420);

      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
      $display("%0d responses: %0d dispatch runs, %0d finished, %0d full, %0d empty",
               rsp_count, n_dispatch, n_finish, n_full, n_empty);
      $display("slice settings 25, 0, 255, 1, 7 and one random value were used");
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire

### priority_round_robin_job_queue_top.f
hdl/prrjq_pkg.sv
hdl/prrjq_slice_calc.sv
hdl/priority_round_robin_job_queue_top.sv
tb/testbench.sv
